>>> src/u8t_pkg.sv
// Shared constants, types and helpers of the 8N1 UART transceiver.
`default_nettype none
package u8t_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int LEVEL_W    = 5;

   localparam logic [15:0] PERIOD_RESET = 16'd5208;
   localparam logic [15:0] PERIOD_MIN   = 16'd4;

   // transmitter bit positions: idle, start, data 0..7, stop
   localparam logic [3:0] TX_IDLE  = 4'd0;
   localparam logic [3:0] TX_START = 4'd1;
   localparam logic [3:0] TX_DATA0 = 4'd2;
   localparam logic [3:0] TX_DATA7 = 4'd9;
   localparam logic [3:0] TX_STOP  = 4'd10;

   // receiver positions: idle, waiting for data bit 0..7, waiting for stop end
   localparam logic [3:0] RX_IDLE  = 4'd0;
   localparam logic [3:0] RX_FIRST = 4'd1;
   localparam logic [3:0] RX_LAST  = 4'd8;
   localparam logic [3:0] RX_STOP  = 4'd9;

   typedef struct packed {
      logic               line;
      logic               busy;
      logic [LEVEL_W-1:0] level;
      logic               dropped;
   } tx_out_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rx_out_type;

   function automatic logic [FIFO_AW-1:0] next_ptr(input logic [FIFO_AW-1:0] ptr);
      logic [FIFO_AW-1:0] res;
      if (ptr == FIFO_AW'(FIFO_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> src/u8t_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module u8t_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> src/u8t_tx.sv
// Transmit FIFO control around the byte RAM, and the 8N1 frame transmitter.
`default_nettype none
module u8t_tx (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                kind,
   input  wire logic [7:0]          tx_byte,
   input  wire logic [15:0]         period,
   output u8t_pkg::tx_out_type      status
);
   import u8t_pkg::*;

   logic [FIFO_AW-1:0] head_ff, head_in;
   logic [FIFO_AW-1:0] tail_ff, tail_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic [3:0]         bit_idx_ff, bit_idx_in;
   logic [15:0]        timer_ff, timer_in;
   logic [7:0]         shift_ff;
   logic               load_ff;
   logic               fwd_ff;
   logic [7:0]         fwd_byte_ff;

   logic               enq_ok;
   logic [FIFO_CW-1:0] count_a;
   logic               start;
   logic [3:0]         idx_a;
   logic [15:0]        timer_a;
   logic [16:0]        timer_inc;
   logic [2:0]         data_sel;
   logic [7:0]         rd_data;

   u8t_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (step && enq_ok),
      .wr_addr (tail_ff),
      .wr_data (tx_byte),
      .rd_en   (step && start),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      enq_ok    = kind && (count_ff < FIFO_CW'(FIFO_DEPTH));
      count_a   = count_ff + FIFO_CW'(enq_ok);
      start     = (bit_idx_ff == TX_IDLE) && (count_a != '0);
      idx_a     = start ? TX_START : bit_idx_ff;
      timer_a   = start ? 16'd0 : timer_ff;
      timer_inc = {1'b0, timer_a} + 17'd1;
      data_sel  = 3'(idx_a - TX_DATA0);

      status.busy    = (idx_a != TX_IDLE);
      status.dropped = kind && !enq_ok;
      if (idx_a == TX_START) begin
         status.line = 1'b0;
      end else if (idx_a >= TX_DATA0 && idx_a <= TX_DATA7) begin
         status.line = shift_ff[data_sel];
      end else begin
         status.line = 1'b1;
      end

      head_in    = start ? next_ptr(head_ff) : head_ff;
      tail_in    = enq_ok ? next_ptr(tail_ff) : tail_ff;
      count_in   = count_a - FIFO_CW'(start);
      bit_idx_in = idx_a;
      timer_in   = timer_a;
      if (idx_a != TX_IDLE) begin
         if (timer_inc >= {1'b0, period}) begin
            timer_in   = 16'd0;
            bit_idx_in = (idx_a == TX_STOP) ? TX_IDLE : idx_a + 4'd1;
         end else begin
            timer_in = timer_inc[15:0];
         end
      end
      status.level = LEVEL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         bit_idx_ff <= TX_IDLE;
         timer_ff   <= 16'd0;
         load_ff    <= 1'b0;
      end else begin
         load_ff <= step && start;
         if (step) begin
            head_ff    <= head_in;
            tail_ff    <= tail_in;
            count_ff   <= count_in;
            bit_idx_ff <= bit_idx_in;
            timer_ff   <= timer_in;
         end
      end
   end

   // a byte written and read at the same entry in one tick bypasses the RAM
   always_ff @(posedge clock) begin
      if (step && start) begin
         fwd_ff      <= enq_ok && (count_ff == '0);
         fwd_byte_ff <= tx_byte;
      end
      if (load_ff) begin
         shift_ff <= fwd_ff ? fwd_byte_ff : rd_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("tx fifo count beyond depth");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      FIFO_AW'(tail_ff - head_ff) == FIFO_AW'(count_ff))
      else $error("tx fifo pointers disagree with count");

   a_load_in_start: assert property (@(posedge clock) disable iff (reset)
      load_ff |-> bit_idx_ff == TX_START)
      else $error("tx shift loaded outside the start bit");

endmodule
`default_nettype wire

>>> src/u8t_rx.sv
// 8N1 frame receiver: falling-edge detect, sampling a quarter period into each bit, byte assembly.
`default_nettype none
module u8t_rx (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic           rx_level,
   input  wire logic [15:0]    period,
   output u8t_pkg::rx_out_type result
);
   import u8t_pkg::*;

   logic [3:0]  bit_idx_ff, bit_idx_in;
   logic [16:0] timer_ff, timer_in;
   logic [7:0]  shift_ff, shift_in;
   logic        last_ff;

   logic [17:0] target;
   logic [17:0] timer_inc;
   logic [2:0]  bit_sel;

   always_comb begin
      // first data sample sits a quarter period past the start bit
      target     = (bit_idx_ff == RX_FIRST) ?
                   {2'b00, period} + {4'b0000, period[15:2]} : {2'b00, period};
      timer_inc  = {1'b0, timer_ff} + 18'd1;
      bit_sel    = 3'(bit_idx_ff - RX_FIRST);
      bit_idx_in = bit_idx_ff;
      timer_in   = timer_ff;
      shift_in   = shift_ff;
      result     = '0;
      if (bit_idx_ff == RX_IDLE) begin
         if (last_ff && !rx_level) begin
            bit_idx_in = RX_FIRST;
            timer_in   = 17'd0;
         end
      end else if (timer_inc >= target) begin
         timer_in = 17'd0;
         if (bit_idx_ff <= RX_LAST) begin
            shift_in[bit_sel] = rx_level;
            bit_idx_in        = bit_idx_ff + 4'd1;
         end else begin
            result.valid = 1'b1;
            result.data  = shift_ff;
            shift_in     = 8'd0;
            bit_idx_in   = RX_IDLE;
         end
      end else begin
         timer_in = timer_inc[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_idx_ff <= RX_IDLE;
         timer_ff   <= 17'd0;
         shift_ff   <= 8'd0;
         last_ff    <= 1'b1;
      end else if (step) begin
         bit_idx_ff <= bit_idx_in;
         timer_ff   <= timer_in;
         shift_ff   <= shift_in;
         last_ff    <= rx_level;
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      bit_idx_ff <= RX_STOP)
      else $error("rx bit position out of range");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      bit_idx_ff == RX_IDLE |-> timer_ff == 17'd0)
      else $error("rx timer running while idle");

   a_idle_shift: assert property (@(posedge clock) disable iff (reset)
      bit_idx_ff == RX_IDLE |-> shift_ff == 8'd0)
      else $error("rx shift register not cleared while idle");

endmodule
`default_nettype wire

>>> src/uart_8n1_transceiver.sv
// Top level of the 8N1 UART transceiver: stream ports, period register, result stage.
//
// Each request transaction is one tick of the serial timebase. It carries the
// sampled receive line and may offer a byte for the 16-entry transmit FIFO
// (req_tuser high); a byte offered to a full FIFO is dropped and flagged.
// Every request yields exactly one response transaction holding the transmit
// line level, a received byte with its valid flag, the busy flag, the FIFO
// fill level and the drop flag for that tick.
// The response comes in the cycle after its request; one request is taken every
// cycle unless a response stalls. The response register takes a new result in the
// same cycle as the old one leaves, so req_tready follows rsp_tready while a response
// is held; a stalled response holds and stalls requests, and no tick advances.
// The FIFO bytes live in a RAM with a registered read; the frame shifter is
// loaded from it in the cycle after a frame starts.
// The bit period register (csr_data, ticks per bit, values below 4 act as 4)
// is written whenever csr_valid is high and applies from the next tick.
// Reset loads 5208 into the period, empties the FIFO and idles the transmitter and the receiver.
`default_nettype none
module uart_8n1_transceiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // tx_byte[7:0], rx_level[8], zero pad
   input  wire logic        req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tx_line[0], rx_byte[8:1], rx_valid[9], tx_busy[10], fifo_level[15:11],
   // tx_dropped[16], zero pad
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   import u8t_pkg::*;

   logic        step;
   logic [15:0] period_ff;
   logic [15:0] period;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff, rsp_data_in;
   tx_out_type  tx_status;
   rx_out_type  rx_result;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign period     = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   u8t_tx u_tx (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .kind    (req_tuser),
      .tx_byte (req_tdata[7:0]),
      .period  (period),
      .status  (tx_status)
   );

   u8t_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_level (req_tdata[8]),
      .period   (period),
      .result   (rx_result)
   );

   assign rsp_data_in = {7'd0, tx_status.dropped, tx_status.level, tx_status.busy,
                         rx_result.valid, rx_result.data, tx_status.line};

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            period_ff <= csr_data;
         end
         if (req_tready) begin
            rsp_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted tick produced no response");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[9] |-> rsp_data_ff[8:1] == 8'd0)
      else $error("received byte nonzero without valid");

   a_line_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[10] |-> rsp_data_ff[0])
      else $error("transmit line low while not busy");

endmodule
`default_nettype wire
